// ===== design/sqp_pkg.sv =====
// shared types and constants for the sensor quantizer and packet framer
package sqp_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned SEQ_W    = 29;
    localparam int unsigned DEV_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_READY = 3'd5;

    // word kinds on the output
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_FORCE  = 2'd1;
    localparam logic [1:0] KIND_ANGLE  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_MAX = 16'hFFFF;

    // quantizer sequencer
    typedef enum logic [1:0] {
        t_Q_IDLE  = 2'd0,
        t_Q_FORCE = 2'd1,
        t_Q_ANGLE = 2'd2,
        t_Q_DONE  = 2'd3
    } t_qstate;

    // framer sequencer
    typedef enum logic [1:0] {
        t_F_IDLE   = 2'd0,
        t_F_HEADER = 2'd1,
        t_F_FORCE  = 2'd2,
        t_F_ANGLE  = 2'd3
    } t_fstate;

    // codes of one quantized pair handed to the framer
    typedef struct packed {
        logic [CODE_W-1:0] force_code;
        logic [CODE_W-1:0] angle_code;
    } t_pair;

endpackage

// ===== design/sensor_quantize_packetizer.sv =====
// Sensor quantizer and packet framer. Each accepted beat carries a force and an
// angle sample; the front quantizer clamps each one and divides with a shared
// restoring divider (17 steps per non-clamped sample, then a done strobe). It takes
// no new beat until the last pair has entered the queue, so the spacing of accepted
// beats is set by the divider and grows while the queue is full. Pairs cross a
// two-entry queue to the framer, which buffers PAIRS_PER_PACKET pairs and, when
// link_ready is set, bursts a header plus 2*PAIRS_PER_PACKET code beats; otherwise
// the packet is dropped while the sequence still advances. The user must write
// range registers only while idle; the block itself does not enforce it.
module sensor_quantize_packetizer import sqp_pkg::*; #(
    parameter int unsigned PAIRS_PER_PACKET = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_force_sample,
    input  logic signed [31:0] i_angle_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_word,
    output logic [1:0]         o_kind,
    output logic               o_last
);
    logic signed [31:0] r_force_min, r_force_max, r_angle_min, r_angle_max;
    logic [DEV_W-1:0]   r_device_id;
    logic               r_link_ready;
    logic  w_q_valid, w_q_stall, w_f_valid, w_f_stall;
    t_pair w_q_pair, w_f_pair;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_min  <= 32'sd0;
            r_force_max  <= 32'sd512000;
            r_angle_min  <= -32'sd23040;
            r_angle_max  <= 32'sd23040;
            r_device_id  <= '0;
            r_link_ready <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FORCE_MIN:  r_force_min  <= i_cfg_data;
                CFG_FORCE_MAX:  r_force_max  <= i_cfg_data;
                CFG_ANGLE_MIN:  r_angle_min  <= i_cfg_data;
                CFG_ANGLE_MAX:  r_angle_max  <= i_cfg_data;
                CFG_DEVICE_ID:  r_device_id  <= i_cfg_data[DEV_W-1:0];
                CFG_LINK_READY: r_link_ready <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sqp_quantizer u_quant (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_force_sample(i_force_sample), .i_angle_sample(i_angle_sample),
        .i_force_min(r_force_min), .i_force_max(r_force_max),
        .i_angle_min(r_angle_min), .i_angle_max(r_angle_max),
        .o_pair_valid(w_q_valid), .i_pair_stall(w_q_stall), .o_pair(w_q_pair)
    );

    sqp_pair_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_stall(w_q_stall), .i_pair(w_q_pair),
        .o_valid(w_f_valid), .i_stall(w_f_stall), .o_pair(w_f_pair)
    );

    sqp_framer #(.PAIRS_PER_PACKET(PAIRS_PER_PACKET)) u_framer (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pair_valid(w_f_valid), .o_pair_stall(w_f_stall), .i_pair(w_f_pair),
        .i_device_id(r_device_id), .i_link_ready(r_link_ready),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_word(o_word), .o_kind(o_kind), .o_last(o_last)
    );

    // last is only ever flagged on an angle beat
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_kind == KIND_ANGLE))
        else $error("last on a non-angle beat");

    // a header beat is always followed by a force beat
    a_hdr_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_kind == KIND_HEADER) |=> (o_valid && o_kind == KIND_FORCE))
        else $error("header not followed by force code");
endmodule

// ===== design/sqp_divider.sv =====
// restoring divider, one quotient bit per cycle, for the quantizer
module sqp_divider import sqp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [49:0] i_num,
    input  logic [33:0] i_den,
    output logic        o_done,
    output logic [CODE_W-1:0] o_quot
);
    // quotient fits 17 bits (< 65536 after rounding, max 65535.5 -> 65535)
    localparam int unsigned QB = 17;

    logic [33:0] r_rem;
    logic [33:0] n_rem;
    logic [QB-1:0] r_quot;
    logic [QB-1:0] n_quot;
    logic [49:0] r_num;
    logic [33:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] w_trial;

    // one shift-subtract step, bringing down the next of the low 17 numerator bits
    always_comb begin
        w_trial = {r_rem, r_num[r_cnt - 5'd1]} - {1'b0, r_den};
        if (!w_trial[34]) begin
            n_rem  = w_trial[33:0];
            n_quot = {r_quot[QB-2:0], 1'b1};
        end else begin
            n_rem  = {r_rem[32:0], r_num[r_cnt - 5'd1]};
            n_quot = {r_quot[QB-2:0], 1'b0};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            // quotient < 2^17, so top 33 numerator bits are below the divisor
            r_rem  <= {1'b0, i_num[49:17]};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot[CODE_W-1:0];
endmodule

// ===== design/sqp_quantizer.sv =====
// front part: accepts sample pairs and quantizes both to 16-bit codes
module sqp_quantizer import sqp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_force_sample,
    input  logic signed [31:0]  i_angle_sample,
    input  logic signed [31:0]  i_force_min,
    input  logic signed [31:0]  i_force_max,
    input  logic signed [31:0]  i_angle_min,
    input  logic signed [31:0]  i_angle_max,
    output logic                o_pair_valid,
    input  logic                i_pair_stall,
    output t_pair               o_pair
);
    t_qstate r_state, n_state;
    logic signed [31:0] r_angle;
    logic [CODE_W-1:0]  r_force_code;
    logic [CODE_W-1:0]  r_angle_code;

    logic signed [31:0] w_v, w_lo, w_hi;
    logic               w_le, w_ge;
    logic [32:0]        w_diff, w_span;
    logic [49:0]        w_num;
    logic [33:0]        w_den;
    logic               w_start, w_direct;
    logic [CODE_W-1:0]  w_direct_code;
    logic               w_div_done;
    logic [CODE_W-1:0]  w_div_quot;
    logic               r_direct;
    logic               w_accept;

    assign w_accept = i_valid && (r_state == t_Q_IDLE);

    // select operands for the sample under work
    always_comb begin
        if (r_state == t_Q_IDLE) begin
            w_v  = i_force_sample;
            w_lo = i_force_min;
            w_hi = i_force_max;
        end else begin
            w_v  = r_angle;
            w_lo = i_angle_min;
            w_hi = i_angle_max;
        end
        w_le   = (w_v <= w_lo);
        w_ge   = (w_v >= w_hi);
        w_diff = 33'(33'(signed'(w_v)) - 33'(signed'(w_lo)));
        w_span = 33'(33'(signed'(w_hi)) - 33'(signed'(w_lo)));
        // round half up: (2*d*65535 + span) / (2*span)
        w_num  = 50'({w_diff, 17'd0} - {16'd0, w_diff, 1'b0}) + 50'(w_span);
        w_den  = {w_span, 1'b0};
        w_direct      = w_le || w_ge;
        w_direct_code = w_le ? '0 : CODE_MAX;
    end

    // the angle division starts as soon as the force code is settled
    assign w_start = (w_accept || (r_state == t_Q_FORCE && (r_direct || w_div_done)))
                     && !w_direct;

    sqp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_Q_IDLE:  if (i_valid) n_state = t_Q_FORCE;
            t_Q_FORCE: if (r_direct || w_div_done) n_state = t_Q_ANGLE;
            t_Q_ANGLE: if (r_direct || w_div_done) n_state = t_Q_DONE;
            t_Q_DONE:  if (!i_pair_stall) n_state = t_Q_IDLE;
            default:   n_state = t_Q_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall      = (r_state != t_Q_IDLE);
        o_pair_valid = (r_state == t_Q_DONE);
        o_pair.force_code = r_force_code;
        o_pair.angle_code = r_angle_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_Q_IDLE;
        else          r_state <= n_state;
    end

    // codes and the direct-result flag
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_angle      <= i_angle_sample;
            r_direct     <= w_direct;
            r_force_code <= w_direct_code;
        end else if (r_state == t_Q_FORCE && (r_direct || w_div_done)) begin
            if (!r_direct) r_force_code <= w_div_quot;
            // angle operands are selected now
            r_direct     <= w_direct;
            r_angle_code <= w_direct_code;
        end else if (r_state == t_Q_ANGLE && !r_direct && w_div_done) begin
            r_angle_code <= w_div_quot;
        end
    end
endmodule

// ===== design/sqp_pair_fifo.sv =====
// short queue of quantized pairs between the quantizer and the framer
module sqp_pair_fifo import sqp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_pair i_pair,
    output logic  o_valid,
    input  logic  i_stall,
    output t_pair o_pair
);
    t_pair      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;
    assign o_pair  = r_mem[r_rp];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_pair;
    end
endmodule

// ===== design/sqp_framer.sv =====
// back part: buffers code pairs and bursts out packets, or drops a packet when the link is not ready
module sqp_framer import sqp_pkg::*; #(
    parameter int unsigned PAIRS_PER_PACKET = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pair_valid,
    output logic              o_pair_stall,
    input  t_pair             i_pair,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic              i_link_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_word,
    output logic [1:0]        o_kind,
    output logic              o_last
);
    localparam int unsigned IW = (PAIRS_PER_PACKET > 1) ? $clog2(PAIRS_PER_PACKET) : 1;
    localparam int unsigned FW = $clog2(PAIRS_PER_PACKET + 1);
    localparam logic [FW-1:0] LAST_FILL = FW'(PAIRS_PER_PACKET - 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(PAIRS_PER_PACKET - 1);

    logic [CODE_W-1:0] r_force [PAIRS_PER_PACKET];
    logic [CODE_W-1:0] r_angle [PAIRS_PER_PACKET];
    logic [FW-1:0]     r_fill;
    logic [SEQ_W-1:0]  r_seq;
    logic [IW-1:0]     r_idx;
    t_fstate           r_state, n_state;
    logic [CODE_W-1:0] r_rd;
    logic              w_take, w_full, w_adv;

    assign w_take = i_pair_valid && (r_state == t_F_IDLE);
    assign w_full = (r_fill == LAST_FILL);
    assign w_adv  = !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_F_IDLE:   if (w_take && w_full && i_link_ready) n_state = t_F_HEADER;
            t_F_HEADER: if (w_adv) n_state = t_F_FORCE;
            t_F_FORCE:  if (w_adv && r_idx == LAST_IDX) n_state = t_F_ANGLE;
            t_F_ANGLE:  if (w_adv && r_idx == LAST_IDX) n_state = t_F_IDLE;
            default:    n_state = t_F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pair_stall = (r_state != t_F_IDLE);
        o_valid      = (r_state != t_F_IDLE);
        o_word       = 32'(r_rd);
        o_kind       = KIND_ANGLE;
        o_last       = 1'b0;
        unique case (r_state)
            t_F_HEADER: begin
                o_word = {i_device_id, r_seq};
                o_kind = KIND_HEADER;
            end
            t_F_FORCE: o_kind = KIND_FORCE;
            t_F_ANGLE: o_last = (r_idx == LAST_IDX);
            default: ;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_F_IDLE;
            r_fill  <= '0;
            r_seq   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_idx <= '0;
                if (w_full) begin
                    r_fill <= '0;
                    r_seq  <= r_seq + 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (w_adv && (r_state == t_F_FORCE || r_state == t_F_ANGLE)) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
        end
    end

    // stores and registered read of the next word
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_force[r_fill[IW-1:0]] <= i_pair.force_code;
            r_angle[r_fill[IW-1:0]] <= i_pair.angle_code;
        end
        if (r_state == t_F_HEADER && w_adv) begin
            r_rd <= r_force[0];
        end else if (r_state == t_F_FORCE && w_adv) begin
            r_rd <= (r_idx == LAST_IDX) ? r_angle[0] : r_force[IW'(r_idx + 1'b1)];
        end else if (r_state == t_F_ANGLE && w_adv && r_idx != LAST_IDX) begin
            r_rd <= r_angle[IW'(r_idx + 1'b1)];
        end
    end
endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the sensor quantizer and packet framer
`timescale 1ns / 100ps

module testbench import sqp_pkg::*; ();

    localparam int PAIRS = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_force_sample = '0;
    logic signed [31:0] i_angle_sample = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_word;
    logic [1:0]  o_kind;
    logic        o_last;

    sensor_quantize_packetizer #(.PAIRS_PER_PACKET(PAIRS)) dut (.*);

    always #5 i_clk = ~i_clk;

    // one expected output beat
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  kind;
        logic        last;
    } t_beat;

    t_beat expected_beats[$];

    // shadow of the block's registers and state
    logic signed [31:0] force_lo, force_hi, angle_lo, angle_hi;
    logic [DEV_W-1:0]   dev_id;
    logic               link_up;
    logic [CODE_W-1:0]  force_codes[PAIRS];
    logic [CODE_W-1:0]  angle_codes[PAIRS];
    int                 pairs_held;
    logic [SEQ_W-1:0]   seq_num;

    int mismatches = 0;
    int beats_seen = 0;
    int packets_sent = 0;
    int items_sent = 0;

    // idling control
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    // clamp and scale one sample to a 16-bit code, rounding half up
    function automatic logic [CODE_W-1:0] scale_code(logic signed [31:0] v,
            logic signed [31:0] lo, logic signed [31:0] hi);
        logic [63:0] num, den;
        if (v <= lo) return '0;
        if (v >= hi) return CODE_MAX;
        den = 64'($signed(64'(hi)) - $signed(64'(lo)));
        num = 64'($signed(64'(v)) - $signed(64'(lo))) * 64'd65535;
        return CODE_W'((2 * num + den) / (2 * den));
    endfunction

    // fold one accepted pair into the packet buffer
    task automatic buffer_pair(logic signed [31:0] f, logic signed [31:0] a);
        force_codes[pairs_held] = scale_code(f, force_lo, force_hi);
        angle_codes[pairs_held] = scale_code(a, angle_lo, angle_hi);
        pairs_held++;
        if (pairs_held == PAIRS) begin
            pairs_held = 0;
            seq_num = seq_num + 1'b1;
            if (link_up) begin
                packets_sent++;
                expected_beats.push_back({{dev_id, seq_num}, KIND_HEADER, 1'b0});
                for (int i = 0; i < PAIRS; i++)
                    expected_beats.push_back({16'h0, force_codes[i], KIND_FORCE, 1'b0});
                for (int i = 0; i < PAIRS; i++)
                    expected_beats.push_back({16'h0, angle_codes[i], KIND_ANGLE,
                        1'(i == PAIRS - 1)});
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FORCE_MIN:  force_lo = val;
            CFG_FORCE_MAX:  force_hi = val;
            CFG_ANGLE_MIN:  angle_lo = val;
            CFG_ANGLE_MAX:  angle_hi = val;
            CFG_DEVICE_ID:  dev_id = val[DEV_W-1:0];
            CFG_LINK_READY: link_up = val[0];
            default: ;
        endcase
    endtask

    // wait until the output queue drains, then let the quantizer settle
    task automatic drain();
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // offer one beat; wait until it is taken
    task automatic send_pair(logic signed [31:0] f, logic signed [31:0] a);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_force_sample <= f;
        i_angle_sample <= a;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        buffer_pair(f, a);
        items_sent++;
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random sample biased toward the current range and the edges
    function automatic logic signed [31:0] pick(logic signed [31:0] lo,
            logic signed [31:0] hi);
        logic [63:0] span;
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return lo + $signed($urandom_range(2)) - 1;
            3: return hi + $signed($urandom_range(2)) - 1;
            4, 5: return $urandom;
            default: begin
                if (hi <= lo) return $urandom;
                span = 64'($signed(64'(hi)) - $signed(64'(lo)));
                return 32'($signed(64'(lo)) + 64'({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    // receiver stall and output checking
    always @(posedge i_clk) begin
        t_beat exp_b;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else
            i_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat word=%h kind=%0d last=%0b",
                        o_word, o_kind, o_last);
            end else begin
                exp_b = expected_beats.pop_front();
                if (o_word !== exp_b.word || o_kind !== exp_b.kind
                        || o_last !== exp_b.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp word=%h kind=%0d last=%0b, got %h %0d %0b",
                            exp_b.word, exp_b.kind, exp_b.last, o_word, o_kind, o_last);
                end
            end
        end
    end

    // directed stimulus table
    typedef struct {
        logic signed [31:0] f;
        logic signed [31:0] a;
        logic [CODE_W-1:0]  f_code;
        logic [CODE_W-1:0]  a_code;
        bit                 typed;
    } t_row;

    t_row dir_rows[16];

    initial begin
        dir_rows[0]  = '{32'h8000_0000, 32'h8000_0000, 16'h0, 16'h0, 1};
        dir_rows[1]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1};
        dir_rows[2]  = '{0, -23040, 16'h0, 16'h0, 1};
        dir_rows[3]  = '{512000, 23040, 16'hFFFF, 16'hFFFF, 1};
        dir_rows[4]  = '{1, -23039, 0, 0, 0};
        dir_rows[5]  = '{511999, 23039, 0, 0, 0};
        dir_rows[6]  = '{256000, 0, 0, 0, 0};
        dir_rows[7]  = '{32'h5555_5555, 32'hAAAA_AAAA, 16'hFFFF, 16'h0, 1};
        dir_rows[8]  = '{-1, 1, 16'h0, 0, 0};
        dir_rows[9]  = '{100, -100, 0, 0, 0};
        dir_rows[10] = '{3, 7, 0, 0, 0};
        dir_rows[11] = '{255999, 256, 0, 0, 0};
        dir_rows[12] = '{128000, -11520, 0, 0, 0};
        dir_rows[13] = '{384000, 11520, 0, 0, 0};
        dir_rows[14] = '{2, -2, 0, 0, 0};
        dir_rows[15] = '{32'hAAAA_AAAA, 32'h5555_5555, 16'h0, 16'hFFFF, 1};
    end

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_pair(pick(force_lo, force_hi), pick(angle_lo, angle_hi));
        go_idle();
    endtask

    // main sequence
    initial begin
        force_lo = 0; force_hi = 512000; angle_lo = -23040; angle_hi = 23040;
        dev_id = 0; link_up = 0; pairs_held = 0; seq_num = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset ranges, link down: packets are dropped but count
        for (int i = 0; i < 8; i++) send_pair(dir_rows[i].f, dir_rows[i].a);
        go_idle();
        drain();
        write_reg(CFG_LINK_READY, 1);
        write_reg(CFG_DEVICE_ID, 7);
        for (int i = 0; i < 16; i++) begin
            send_pair(dir_rows[i].f, dir_rows[i].a);
            if (dir_rows[i].typed && (force_codes[(pairs_held + 7) % 8] !== dir_rows[i].f_code
                    || angle_codes[(pairs_held + 7) % 8] !== dir_rows[i].a_code)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d predicted code differs from typed value", i);
            end
        end
        go_idle();
        drain();

        // phase: extreme ranges, no idling
        write_reg(CFG_FORCE_MIN, 32'h8000_0000);
        write_reg(CFG_FORCE_MAX, 32'h7FFF_FFFF);
        write_reg(CFG_ANGLE_MIN, 32'h7FFF_FFFF);
        write_reg(CFG_ANGLE_MAX, 32'h8000_0000);
        write_reg(CFG_DEVICE_ID, 0);
        run_random(64);
        drain();

        // phase: narrow ranges, long receiver hold-off, then the sender idles
        write_reg(CFG_FORCE_MIN, -5);
        write_reg(CFG_FORCE_MAX, 5);
        write_reg(CFG_ANGLE_MIN, 100);
        write_reg(CFG_ANGLE_MAX, 100);
        write_reg(CFG_DEVICE_ID, 5);
        hold_cycles = 3000;
        run_random(40);
        send_idle_pct = 53;
        run_random(40);
        drain();

        // phase: receiver stalls, link down then up
        send_idle_pct = 0;
        recv_stall_pct = 53;
        write_reg(CFG_FORCE_MIN, $urandom);
        write_reg(CFG_FORCE_MAX, $urandom);
        write_reg(CFG_ANGLE_MIN, -1000000);
        write_reg(CFG_ANGLE_MAX, 1000000);
        write_reg(CFG_LINK_READY, 0);
        run_random(24);
        drain();
        write_reg(CFG_LINK_READY, 1);
        write_reg(CFG_DEVICE_ID, 3);
        run_random(64);
        drain();

        // phase: both sides idle
        send_idle_pct = 12;
        recv_stall_pct = 12;
        write_reg(CFG_FORCE_MIN, -512000);
        write_reg(CFG_FORCE_MAX, 512000);
        write_reg(CFG_ANGLE_MIN, -23040);
        write_reg(CFG_ANGLE_MAX, 23040);
        run_random(112);
        drain();

        $display("covered %0d samples, %0d packets framed, %0d beats checked",
            items_sent, packets_sent, beats_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else begin
            $display("%0d mismatches in total", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
design/sqp_pkg.sv
design/sqp_divider.sv
design/sqp_quantizer.sv
design/sqp_pair_fifo.sv
design/sqp_framer.sv
design/sensor_quantize_packetizer.sv
sim/testbench.sv
